### sv/emfd_pkg.sv
// ---------------------------------------------------------------------------
// emfd_pkg: shared types and constants of the meter frame decoder
// Frame layout constants, status codes, channel payloads and state encoding.
// ---------------------------------------------------------------------------
package emfd_pkg;

	localparam int FRAME_LEN = 24;
	localparam int LAST_POS  = 23;
	localparam int POS_W     = 5;
	localparam int ADDR_W    = 5;
	localparam int VAL_W     = 40;
	localparam int CAL_W     = 24;

	// value words start at byte 2, adjustment byte sits at byte 20
	localparam int FIRST_WORD = 2;
	localparam int ADJ_POS    = 20;
	localparam int RD_LAST    = ADJ_POS - FIRST_WORD + 1;

	localparam logic [7:0] HEAD1      = 8'h55;
	localparam logic [7:0] HEAD2      = 8'hFA;
	localparam logic [7:0] UNCAL      = 8'hAA;
	localparam logic [7:0] FAULT_MASK = 8'hF0;
	localparam logic [15:0] GAP_RESET = 16'd500;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_UNCAL = 3'd1,
		ST_FAULT = 3'd2,
		ST_HEAD1 = 3'd3,
		ST_HEAD2 = 3'd4,
		ST_SUM   = 3'd5
	} status_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	// input channel payload
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] rx_byte;
	} rx_item_t;

	// result channel payload
	typedef struct packed {
		status_t          status;
		logic [3:0]       fault_flags;
		logic             voltage_valid;
		logic [VAL_W-1:0] voltage;
		logic             current_valid;
		logic [VAL_W-1:0] current;
		logic             power_valid;
		logic [VAL_W-1:0] power;
	} meter_result_t;

	// register write payload
	typedef logic [15:0] gap_cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_WAIT,
		S_OUT
	} state_t;

	// start request to the divider
	typedef struct packed {
		logic              start;
		logic [CAL_W-1:0]  calib;
		logic [CAL_W-1:0]  cycle;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [VAL_W-1:0]  quot;
	} div_rsp_t;

endpackage

### sv/emfd_if.sv
// ---------------------------------------------------------------------------
// emfd_if: valid/ready channel
// Generic payload channel with source and sink modports.
// ---------------------------------------------------------------------------
interface emfd_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### sv/emfd_ram.sv
// ---------------------------------------------------------------------------
// emfd_ram: single-port synchronous RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module emfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### sv/emfd_div.sv
// ---------------------------------------------------------------------------
// emfd_div: restoring divider
// (calib << FRAC_BITS) / cycle, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module emfd_div
	import emfd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int NUM_W = CAL_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [CAL_W:0]   rem_q;
	logic [CAL_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CAL_W:0]   shifted;
	logic [CAL_W:0]   diff;

	assign shifted = {rem_q[CAL_W-1:0], num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	// iterate over numerator bits, quotient shifts into num_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && cnt_q == CNT_W'(1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= NUM_W'(req.calib) << FRAC_BITS;
			rem_q <= '0;
			den_q <= req.cycle;
		end else if (busy_q) begin
			if (!diff[CAL_W]) begin
				rem_q <= diff;
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quot: VAL_W'(num_q)};
endmodule

### sv/energy_meter_frame_decoder.sv
// ---------------------------------------------------------------------------
// energy_meter_frame_decoder: 24-byte meter frame deframer
// Stores frame bytes in a RAM, checks headers and checksum, divides values.
// ---------------------------------------------------------------------------
// in  : cmd (0 byte, 1 millisecond tick) and rx_byte, valid/ready.
// out : one result per rejected byte or completed frame, valid/ready.
// cfg : gap_timeout_ticks write channel, taken at any time (use while idle).
// An error result is registered the cycle after the transfer. A good frame
// end reads bytes 2..21 from the frame RAM (one per cycle), keeps 2..20,
// and runs three serial divisions on one shared divider, each a start
// state (S_DIV) and a wait state (S_WAIT) until the divider is done; the
// result then goes out through S_OUT.
// in.ready is low while a result is being built or is waiting in the output
// register; a stalled receiver holds the result and the input stays blocked.
// Reset clears position, checksum, idle count, timeout (500) and the output.
// Frame RAM contents are not cleared; each frame rewrites what it reads.
// ---------------------------------------------------------------------------
module energy_meter_frame_decoder
	import emfd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	emfd_if.sink   in,
	emfd_if.sink   cfg,
	emfd_if.source out
);
	state_t state_q, state_d;

	logic [15:0]      gap_q, idle_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [ADDR_W-1:0] addr;
	logic             we;
	logic [7:0]       rdata;
	logic [ADDR_W-1:0] rd_q;
	logic [7:0]       adj_q;
	logic [CAL_W-1:0] w_q [6];
	logic [1:0]       dsel_q;
	div_req_t         req;
	div_rsp_t         rsp;

	logic             ov_q;
	status_t          st_q;
	logic [3:0]       ff_q;
	logic [2:0]       vv_q;
	logic [VAL_W-1:0] val_q [3];

	cmd_t             cmd;
	logic [7:0]       b;
	logic [POS_W-1:0] pos;
	logic             acc;

	assign cmd = in.data.cmd;
	assign b   = in.data.rx_byte;
	assign pos = (pos_q >= POS_W'(FRAME_LEN)) ? '0 : pos_q;
	assign acc = in.valid && in.ready;
	assign in.ready  = (state_q == S_IDLE) && !ov_q;
	assign cfg.ready = 1'b1;

	// RAM port: byte write in idle, sequential reads of bytes 2..21 otherwise
	assign we   = acc && cmd == CMD_BYTE && pos >= POS_W'(2);
	assign addr = we ? pos : ADDR_W'(FIRST_WORD) + rd_q;

	emfd_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(b), .rdata(rdata)
	);

	emfd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (acc && cmd == CMD_BYTE && pos == POS_W'(LAST_POS) && sum_q == b)
				state_d = S_READ;
			S_READ: if (rd_q == ADDR_W'(RD_LAST)) state_d = S_DIV;
			S_DIV:  state_d = S_WAIT;
			S_WAIT: if (rsp.done) state_d = (dsel_q == 2'd2) ? S_OUT : S_DIV;
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// divider request
	always_comb begin
		req.start = (state_q == S_DIV);
		req.calib = w_q[{dsel_q, 1'b0}];
		req.cycle = w_q[{dsel_q, 1'b1}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gap_q   <= GAP_RESET;
			idle_q  <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			ov_q    <= 1'b0;
			rd_q    <= '0;
			dsel_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) gap_q <= cfg.data;
			if (state_q == S_OUT) ov_q <= 1'b1;
			else if (out.valid && out.ready) ov_q <= 1'b0;
			if (state_q == S_READ) rd_q <= rd_q + 1'b1;
			if (state_q == S_WAIT && rsp.done) dsel_q <= dsel_q + 1'b1;
			if (acc && cmd == CMD_TICK) begin
				if (idle_q != 16'hFFFF) idle_q <= idle_q + 1'b1;
				if ((idle_q != 16'hFFFF ? idle_q + 16'd1 : idle_q) >= gap_q)
					pos_q <= '0;
			end else if (acc) begin
				idle_q <= '0;
				rd_q   <= '0;
				dsel_q <= '0;
				if (pos == '0) begin
					if (b == HEAD1) begin
						pos_q <= POS_W'(1);
						sum_q <= '0;
					end else begin
						pos_q <= '0;
						ov_q  <= 1'b1;
					end
				end else if (pos == POS_W'(1)) begin
					if (b == HEAD2) pos_q <= POS_W'(2);
					else begin
						pos_q <= '0;
						ov_q  <= 1'b1;
					end
				end else if (pos != POS_W'(LAST_POS)) begin
					sum_q <= sum_q + b;
					pos_q <= pos + 1'b1;
				end else begin
					pos_q <= '0;
					if (sum_q != b) ov_q <= 1'b1;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_BYTE) begin
			vv_q  <= '0;
			val_q <= '{default: '0};
			if (pos == '0) begin
				if (b == UNCAL) begin
					st_q <= ST_UNCAL;
					ff_q <= '0;
				end else if ((b & FAULT_MASK) == FAULT_MASK) begin
					st_q <= ST_FAULT;
					ff_q <= b[3:0];
				end else begin
					st_q <= ST_HEAD1;
					ff_q <= '0;
				end
			end else begin
				ff_q <= '0;
				if (pos == POS_W'(1)) st_q <= ST_HEAD2;
				else st_q <= (sum_q != b) ? ST_SUM : ST_OK;
			end
		end else if (state_q == S_WAIT && rsp.done) begin
			case (dsel_q)
				2'd0: if (adj_q[6] && w_q[1] != '0) begin
					vv_q[0] <= 1'b1; val_q[0] <= rsp.quot;
				end
				2'd1: if (adj_q[5] && w_q[3] != '0 && w_q[5] != '0) begin
					vv_q[1] <= 1'b1; val_q[1] <= rsp.quot;
				end
				default: if (adj_q[4] && w_q[5] != '0) begin
					vv_q[2] <= 1'b1; val_q[2] <= rsp.quot;
				end
			endcase
		end
	end

	// frame word assembly: read data of byte 1+rd_q arrives while rd_q is
	// 1..19; bytes 2..19 shift through the six words, byte 20 is adj
	always_ff @(posedge clk) begin
		if (state_q == S_READ && rd_q != '0) begin
			if (rd_q == ADDR_W'(RD_LAST))
				adj_q <= rdata;
			else begin
				for (int i = 0; i < 5; i++)
					w_q[i] <= {w_q[i][15:0], w_q[i+1][23:16]};
				w_q[5] <= {w_q[5][15:0], rdata};
			end
		end
	end

	assign out.valid = ov_q;
	always_comb begin
		out.data.status        = st_q;
		out.data.fault_flags   = ff_q;
		out.data.voltage_valid = vv_q[0];
		out.data.voltage       = val_q[0];
		out.data.current_valid = vv_q[1];
		out.data.current       = val_q[1];
		out.data.power_valid   = vv_q[2];
		out.data.power         = val_q[2];
	end

	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !in.ready) else $error("input open while result pending");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(LAST_POS)) else $error("position out of range");
	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_WAIT) else $error("stray divider done");
endmodule

### bench/emfd_tb_pkg.sv
// ---------------------------------------------------------------------------
// emfd_tb_pkg: constants of the frame decoder bench
// Idle and hold-off lengths shared by the stimulus processes.
// ---------------------------------------------------------------------------
package emfd_tb_pkg;

	// longest idle draw of either side, in cycles
	localparam int IDLE_MAX = 17;

	// length of the one long receiver hold-off, in cycles
	localparam int LONG_HOLD = 400;
endpackage

### bench/emfd_checker.sv
// ---------------------------------------------------------------------------
// emfd_checker: frame decoder predictor and result checker
// Watches the input, register and result channels, mirrors the deframing
// state, queues every expected result and compares field-wise.
// ---------------------------------------------------------------------------
module emfd_checker
	import emfd_pkg::*;
	import emfd_tb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  rx_item_t      in_data,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  gap_cfg_t      cfg_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  meter_result_t out_data,
	output int            pending,
	output int            errors
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  frame_bytes [FRAME_LEN];
	logic [4:0]  pos_q;
	logic [7:0]  sum_q;
	logic [15:0] idle_q;
	logic [15:0] gap_limit;
	meter_result_t awaited [$];

	function automatic logic [VAL_W-1:0] fixed_quot(logic [23:0] calib, logic [23:0] cyc);
		logic [63:0] num;
		num = 64'(calib) << FRAC_BITS;
		return VAL_W'(num / 64'(cyc));
	endfunction

	function automatic logic [23:0] word_at(int at);
		return {frame_bytes[at], frame_bytes[at+1], frame_bytes[at+2]};
	endfunction

	function automatic meter_result_t error_result(status_t st, logic [3:0] flags);
		meter_result_t r;
		r = '0;
		r.status = st;
		r.fault_flags = flags;
		return r;
	endfunction

	function automatic meter_result_t frame_result();
		meter_result_t r;
		logic [23:0] vcyc, ccyc, pcyc;
		logic [7:0] adj;
		r = '0;
		r.status = ST_OK;
		vcyc = word_at(5);
		ccyc = word_at(11);
		pcyc = word_at(17);
		adj = frame_bytes[20];
		if (adj[6] && vcyc != 0) begin
			r.voltage_valid = 1'b1;
			r.voltage = fixed_quot(word_at(2), vcyc);
		end
		if (adj[5] && ccyc != 0 && pcyc != 0) begin
			r.current_valid = 1'b1;
			r.current = fixed_quot(word_at(8), ccyc);
		end
		if (adj[4] && pcyc != 0) begin
			r.power_valid = 1'b1;
			r.power = fixed_quot(word_at(14), pcyc);
		end
		return r;
	endfunction

	// one accepted input item: update the mirror, queue any result
	task automatic decode_item(rx_item_t it);
		int p;
		logic [7:0] b;
		b = it.rx_byte;
		if (it.cmd == CMD_TICK) begin
			if (idle_q != 16'hFFFF) idle_q = idle_q + 1;
			if (idle_q >= gap_limit) pos_q = 0;
			return;
		end
		idle_q = 0;
		p = (pos_q >= FRAME_LEN) ? 0 : pos_q;
		if (p == 0) begin
			pos_q = 0;
			if (b == UNCAL) awaited.push_back(error_result(ST_UNCAL, 4'h0));
			else if ((b & FAULT_MASK) == FAULT_MASK)
				awaited.push_back(error_result(ST_FAULT, b[3:0]));
			else if (b != HEAD1) awaited.push_back(error_result(ST_HEAD1, 4'h0));
			else begin
				frame_bytes[0] = b;
				sum_q = 0;
				pos_q = 1;
			end
		end else if (p == 1) begin
			if (b != HEAD2) begin
				pos_q = 0;
				awaited.push_back(error_result(ST_HEAD2, 4'h0));
			end else begin
				frame_bytes[1] = b;
				pos_q = 2;
			end
		end else begin
			frame_bytes[p] = b;
			if (p < LAST_POS) begin
				sum_q = sum_q + b;
				pos_q = 5'(p + 1);
			end else begin
				pos_q = 0;
				if (sum_q != b) awaited.push_back(error_result(ST_SUM, 4'h0));
				else awaited.push_back(frame_result());
			end
		end
	endtask

	task automatic compare_result(meter_result_t got);
		meter_result_t exp_r;
		if (awaited.size() == 0) begin
			$error("unexpected result transfer: %p", got);
			errors++;
			return;
		end
		exp_r = awaited.pop_front();
		if (got.status != exp_r.status) begin
			$error("status: expected %0d, got %0d", exp_r.status, got.status);
			errors++;
		end
		if (got.fault_flags != exp_r.fault_flags) begin
			$error("fault_flags: expected %h, got %h", exp_r.fault_flags, got.fault_flags);
			errors++;
		end
		if (got.voltage_valid != exp_r.voltage_valid) begin
			$error("voltage_valid: expected %b, got %b", exp_r.voltage_valid, got.voltage_valid);
			errors++;
		end
		if (got.voltage != exp_r.voltage) begin
			$error("voltage: expected %h, got %h", exp_r.voltage, got.voltage);
			errors++;
		end
		if (got.current_valid != exp_r.current_valid) begin
			$error("current_valid: expected %b, got %b", exp_r.current_valid, got.current_valid);
			errors++;
		end
		if (got.current != exp_r.current) begin
			$error("current: expected %h, got %h", exp_r.current, got.current);
			errors++;
		end
		if (got.power_valid != exp_r.power_valid) begin
			$error("power_valid: expected %b, got %b", exp_r.power_valid, got.power_valid);
			errors++;
		end
		if (got.power != exp_r.power) begin
			$error("power: expected %h, got %h", exp_r.power, got.power);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		pos_q = 0;
		sum_q = 0;
		idle_q = 0;
		gap_limit = GAP_RESET;
		foreach (frame_bytes[i]) frame_bytes[i] = '0;
	end

	// results first: a result in flight belongs to an earlier item
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) compare_result(out_data);
			if (cfg_valid && cfg_ready) gap_limit = cfg_data;
			if (in_valid && in_ready) decode_item(in_data);
			pending = awaited.size();
		end
	end
endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb: meter frame decoder testbench
// Drives bytes and ticks through directed cases, then mostly well-formed
// random frames with gaps, broken frames and noise over several timeouts;
// a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
	import emfd_pkg::*;
	import emfd_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   pending, errors;
	int   sent = 0;
	bit   no_idle = 1'b0;
	bit   hold_req = 1'b0;
	logic [15:0] cur_gap = GAP_RESET;

	emfd_if #(.payload_t(rx_item_t))      in_ch();
	emfd_if #(.payload_t(gap_cfg_t))      cfg_ch();
	emfd_if #(.payload_t(meter_result_t)) out_ch();

	always #6 clk = ~clk;

	energy_meter_frame_decoder #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .cfg(cfg_ch.sink), .out(out_ch.source)
	);

	emfd_checker #(.FRAC_BITS(FRAC)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.pending(pending), .errors(errors)
	);

	// one input transfer, then the sender's gap
	task automatic push_item(cmd_t c, logic [7:0] b);
		int gap;
		in_ch.valid = 1'b1;
		in_ch.data = '{cmd: c, rx_byte: b};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		sent++;
		gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
		if (sent % 97 == 0) no_idle = ~no_idle;
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic push_ticks(int n);
		repeat (n) push_item(CMD_TICK, 8'($urandom));
	endtask

	// wait for all results, then hold the input idle before returning
	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_gap(logic [15:0] v);
		drain();
		cfg_ch.valid = 1'b1;
		cfg_ch.data = v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		cur_gap = v;
	endtask

	function automatic logic [23:0] pick_word(bit allow_zero);
		case ($urandom_range(0, 5))
			0: return allow_zero ? 24'h0 : 24'h1;
			1: return 24'hFFFFFF;
			2: return 24'h1;
			default: return 24'($urandom);
		endcase
	endfunction

	// flaw: 0 good, 1 bad second header, 2 bad checksum, 3 idle gap inside
	task automatic push_frame(int flaw, logic [7:0] adj);
		logic [7:0] fb [FRAME_LEN];
		logic [23:0] w;
		logic [7:0] sum;
		int cut;
		fb[0] = HEAD1;
		fb[1] = HEAD2;
		for (int k = 0; k < 6; k++) begin
			w = pick_word(k % 2 == 1);
			fb[2+3*k] = w[23:16];
			fb[3+3*k] = w[15:8];
			fb[4+3*k] = w[7:0];
		end
		fb[20] = adj;
		fb[21] = 8'($urandom);
		fb[22] = 8'($urandom);
		sum = 0;
		for (int k = 2; k < LAST_POS; k++) sum += fb[k];
		fb[23] = sum;
		if (flaw == 1) fb[1] = fb[1] ^ 8'(1 << $urandom_range(0, 7));
		if (flaw == 2) fb[23] = sum + 8'($urandom_range(1, 255));
		cut = (flaw == 3) ? $urandom_range(1, 22) : FRAME_LEN;
		for (int k = 0; k < FRAME_LEN; k++) begin
			if (k == cut) push_ticks((cur_gap <= 40) ? cur_gap : 3);
			if (flaw == 1 && k == 2) break;
			push_item(CMD_BYTE, fb[k]);
		end
	endtask

	task automatic random_phase(int n_items);
		int stop;
		int r;
		stop = sent + n_items;
		while (sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 60) push_frame(0, 8'($urandom));
			else if (r < 68) push_frame(1, 8'($urandom));
			else if (r < 76) push_frame(2, 8'($urandom));
			else if (r < 84) push_frame(3, 8'($urandom));
			else if (r < 92) push_item(CMD_BYTE, 8'($urandom));
			else push_ticks($urandom_range(1, 4));
		end
	endtask

	// result receiver with random stalls and one long hold-off on request
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
			if (hold_req) begin
				stall = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: error bytes, extremes, gating and gaps
		push_item(CMD_BYTE, UNCAL);
		push_item(CMD_BYTE, 8'hF0);
		push_item(CMD_BYTE, 8'hFF);
		push_item(CMD_BYTE, 8'hF5);
		push_item(CMD_BYTE, 8'h00);
		push_item(CMD_BYTE, HEAD1);
		push_item(CMD_BYTE, 8'h05);
		push_frame(0, 8'h70);
		push_frame(0, 8'h40);
		push_frame(0, 8'h00);
		push_frame(2, 8'h70);
		push_frame(1, 8'h70);
		push_ticks(2);

		// long receiver hold while error bytes keep coming
		hold_req = 1'b1;
		for (int k = 0; k < 12; k++) push_item(CMD_BYTE, 8'($urandom_range(0, 84)));
		random_phase(200);

		write_gap(16'd1);
		push_frame(3, 8'h70);
		random_phase(250);
		write_gap(16'd0);
		push_frame(3, 8'h70);
		random_phase(200);
		write_gap(16'hFFFF);
		random_phase(250);
		write_gap(16'd7);
		push_frame(3, 8'h70);
		random_phase(250);

		drain();
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
